FILE: rtl/prc_pkg.sv
// Package for the page reference count table: codes, field widths,
// payload structs and parameter defaults. No dependencies.
package prc_pkg;

  // Fixed field widths of the two channels and the limit register
  localparam int unsigned OP_W     = 2;
  localparam int unsigned ADDR_W   = 48;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned REF_W    = 16;
  localparam int unsigned GROUPS_W = 7;
  localparam int unsigned LIMIT_W  = 17;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

  // Operation codes; the unused code behaves as a query
  localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_ABSENT    = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_SATURATED = 3'd4;

  // Parameter defaults
  localparam int unsigned NUM_PAGES_DEF  = 65536;
  localparam int unsigned GROUP_SIZE_DEF = 1024;
  localparam int unsigned PAGE_BITS_DEF  = 12;
  localparam int unsigned COUNT_BITS_DEF = 16;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] phys_address;
  } in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [REF_W-1:0]    ref_count;
    logic [GROUPS_W-1:0] groups_in_use;
  } out_t;

endpackage

FILE: rtl/prc_alu.sv
// Shared add/subtract unit of the page reference count table.
// Depends on nothing; the top level steps it through each item.
module prc_alu #(
  parameter int unsigned W = 32
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o,
  output logic         carry_o
);

  logic [W-1:0] b_eff;
  logic [W:0]   full;

  // Subtract as a plus inverted b plus one; carry out means a >= b
  assign b_eff = sub_i ? ~b_i : b_i;
  assign full  = {1'b0, a_i} + {1'b0, b_eff} + {{W{1'b0}}, sub_i};

  assign sum_o   = full[W-1:0];
  assign carry_o = full[W];

endmodule

FILE: rtl/page_reference_count_table_top.sv
// Top level of the page reference count table: sequencer, count and group
// memories, limit register and result register. Depends on prc_pkg, prc_alu.
//
// Usage: after reset the block sweeps both memories to zero (one page entry
// a cycle, group entries alongside) and holds in_ready_o low meanwhile; the
// limit register can be written during the sweep. It then works on one beat
// at a time. Every beat passes the range compare; one out of range then goes
// to the done state. A query, a saturated add or a failed remove goes on
// through the page count step; a successful add or remove also through the
// group step, and the present group total step when the number of present
// groups changes. The single adder is stepped through the range compare,
// the page count, the group's used count and the present group total in
// turn; the memories have one registered read. A finished item holds until
// the result register is free. The next beat is taken as soon as the
// sequencer is back in idle, even while the previous result still waits on
// the output. GROUP_SIZE must be a power of two; the group of a page is its
// index shifted right. The user must write the limit register only while
// idle; the block itself does not enforce this.
module page_reference_count_table_top import prc_pkg::*; #(
  parameter int unsigned NUM_PAGES  = NUM_PAGES_DEF,
  parameter int unsigned GROUP_SIZE = GROUP_SIZE_DEF,
  parameter int unsigned PAGE_BITS  = PAGE_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_we_i,
  input  logic [LIMIT_W-1:0] cfg_wdata_i
);

  // Derived sizes
  localparam int unsigned IDX_W       = ADDR_W - PAGE_BITS;
  localparam int unsigned NUM_GROUPS  = (NUM_PAGES + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int unsigned PAGE_AW     = $clog2(NUM_PAGES);
  localparam int unsigned GROUP_SHIFT = $clog2(GROUP_SIZE);
  localparam int unsigned GROUP_AW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned USED_W      = $clog2(GROUP_SIZE + 1);
  localparam int unsigned TOTAL_W     = $clog2(NUM_GROUPS + 1);
  localparam int unsigned GENT_W      = USED_W + 1;
  localparam int unsigned W1          = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int unsigned W2          = (USED_W > W1) ? USED_W : W1;
  localparam int unsigned ALU_W       = (TOTAL_W > W2) ? TOTAL_W : W2;

  // Sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RANGE = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_GROUP = 3'd4;
  localparam logic [2:0] S_TOTAL = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [PAGE_AW-1:0]    clr_q, clr_d;
  logic [LIMIT_W-1:0]    limit_q;
  logic [TOTAL_W-1:0]    total_q, total_d;
  logic [OP_W-1:0]       op_q;
  logic [IDX_W-1:0]      idx_q;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic [COUNT_BITS-1:0] refc_q, refc_d;
  logic                  upd_used_q, upd_used_d;
  logic                  tot_dec_q, tot_dec_d;
  logic                  out_valid_q;
  out_t                  out_q;

  // Memories: page counts, and per group {present, used}
  logic [COUNT_BITS-1:0] page_mem [NUM_PAGES];
  logic [GENT_W-1:0]     grp_mem  [NUM_GROUPS];
  logic [COUNT_BITS-1:0] page_rd_q;
  logic [GENT_W-1:0]     grp_rd_q;

  logic [PAGE_AW-1:0]    page_addr, page_waddr;
  logic [GROUP_AW-1:0]   grp_addr, grp_waddr;
  logic                  page_we, grp_we;
  logic [COUNT_BITS-1:0] page_wdata;
  logic [GENT_W-1:0]     grp_wdata;

  // Shared adder
  logic [ALU_W-1:0]      alu_a, alu_b, alu_sum;
  logic                  alu_sub, alu_carry;

  logic                  in_acc, is_add, is_rem, out_free;
  logic                  oor, cnt_max, cnt_zero, cnt_one;
  logic                  grp_present;
  logic [USED_W-1:0]     grp_used, used_new;
  logic                  do_used;

  prc_alu #(
    .W (ALU_W)
  ) u_alu (
    .a_i     (alu_a),
    .b_i     (alu_b),
    .sub_i   (alu_sub),
    .sum_o   (alu_sum),
    .carry_o (alu_carry)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign is_add     = (op_q == OP_ADD);
  assign is_rem     = (op_q == OP_REMOVE);

  assign page_addr  = idx_q[PAGE_AW-1:0];
  assign grp_addr   = GROUP_AW'(page_addr >> GROUP_SHIFT);

  assign cnt_max    = &page_rd_q;
  assign cnt_zero   = (page_rd_q == '0);
  assign cnt_one    = (page_rd_q == COUNT_BITS'(1));
  assign grp_present = grp_rd_q[USED_W];
  assign grp_used    = grp_rd_q[USED_W-1:0];
  assign used_new    = alu_sum[USED_W-1:0];
  // Bump the used count on a page's first reference; drop it on the last one
  assign do_used     = upd_used_q && (is_add || (grp_used != '0));

  // Index at or above the limit register, beyond the store, or above 17 bits
  assign oor = alu_carry || (|idx_q[IDX_W-1:LIMIT_W]) ||
               (idx_q >= IDX_W'(NUM_PAGES));

  // Steer the adder by state
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_q)
      S_RANGE: begin
        alu_a   = ALU_W'(idx_q[LIMIT_W-1:0]);
        alu_b   = ALU_W'(limit_q);
        alu_sub = 1'b1;
      end
      S_COUNT: begin
        alu_a   = ALU_W'(page_rd_q);
        alu_b   = ALU_W'(1);
        alu_sub = is_rem;
      end
      S_GROUP: begin
        alu_a   = grp_present ? ALU_W'(grp_used) : '0;
        alu_b   = ALU_W'(do_used);
        alu_sub = is_rem;
      end
      S_TOTAL: begin
        alu_a   = ALU_W'(total_q);
        alu_b   = ALU_W'(1);
        alu_sub = tot_dec_q;
      end
      default: begin
        alu_a   = '0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    total_d    = total_q;
    status_d   = status_q;
    refc_d     = refc_q;
    upd_used_d = upd_used_q;
    tot_dec_d  = tot_dec_q;
    page_we    = 1'b0;
    page_waddr = page_addr;
    page_wdata = alu_sum[COUNT_BITS-1:0];
    grp_we     = 1'b0;
    grp_waddr  = grp_addr;
    grp_wdata  = {is_add || (used_new != '0), used_new};

    unique case (state_q)
      S_CLEAR: begin
        page_we    = 1'b1;
        page_waddr = clr_q;
        page_wdata = '0;
        grp_we     = (clr_q < PAGE_AW'(NUM_GROUPS));
        grp_waddr  = GROUP_AW'(clr_q);
        grp_wdata  = '0;
        clr_d      = clr_q + PAGE_AW'(1);
        if (clr_q == PAGE_AW'(NUM_PAGES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RANGE;
        end
      end
      S_RANGE: begin
        // Memory reads are issued here; data is ready in the next state
        if (oor) begin
          status_d = STAT_RANGE;
          refc_d   = '0;
          state_d  = S_DONE;
        end else begin
          state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        status_d   = STAT_OK;
        upd_used_d = 1'b0;
        state_d    = S_DONE;
        if (is_add) begin
          if (cnt_max) begin
            status_d = STAT_SATURATED;
            refc_d   = page_rd_q;
          end else begin
            page_we    = 1'b1;
            refc_d     = alu_sum[COUNT_BITS-1:0];
            upd_used_d = cnt_zero;
            state_d    = S_GROUP;
          end
        end else if (is_rem) begin
          if (!grp_present) begin
            status_d = STAT_ABSENT;
            refc_d   = '0;
          end else if (cnt_zero) begin
            status_d = STAT_UNDERFLOW;
            refc_d   = '0;
          end else begin
            page_we    = 1'b1;
            refc_d     = alu_sum[COUNT_BITS-1:0];
            upd_used_d = cnt_one;
            state_d    = S_GROUP;
          end
        end else begin
          refc_d = grp_present ? page_rd_q : '0;
        end
      end
      S_GROUP: begin
        grp_we = 1'b1;
        if (is_add && !grp_present) begin
          tot_dec_d = 1'b0;
          state_d   = S_TOTAL;
        end else if (is_rem && (used_new == '0) && (total_q != '0)) begin
          tot_dec_d = 1'b1;
          state_d   = S_TOTAL;
        end else begin
          state_d = S_DONE;
        end
      end
      S_TOTAL: begin
        total_d = alu_sum[TOTAL_W-1:0];
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      limit_q     <= LIMIT_RESET;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      total_q <= total_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      // Load the result when the slot frees; otherwise drop it once taken
      if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload and item registers
  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    refc_q     <= refc_d;
    upd_used_q <= upd_used_d;
    tot_dec_q  <= tot_dec_d;
    if (in_acc) begin
      op_q  <= in_data_i.operation;
      idx_q <= in_data_i.phys_address[ADDR_W-1:PAGE_BITS];
    end
    if (state_q == S_DONE && out_free) begin
      out_q.status        <= status_q;
      out_q.ref_count     <= REF_W'(refc_q);
      out_q.groups_in_use <= GROUPS_W'(total_q);
    end
  end

  // Page count memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    page_rd_q <= page_mem[page_addr];
    if (page_we) begin
      page_mem[page_waddr] <= page_wdata;
    end
  end

  // Group memory
  always_ff @(posedge clk_i) begin
    grp_rd_q <= grp_mem[grp_addr];
    if (grp_we) begin
      grp_mem[grp_waddr] <= grp_wdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks
  a_rose_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result appeared without a finished item");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= TOTAL_W'(NUM_GROUPS))
    else $error("present group total exceeds group count");

  a_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.status == STAT_RANGE) |-> (out_q.ref_count == '0))
    else $error("range error carries a nonzero count");

  a_total_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_TOTAL) |=> (total_q == $past(total_q)))
    else $error("present group total changed outside its step");

endmodule

FILE: bench/page_reference_count_table_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for page_reference_count_table_top: directed, back-to-back and random
// page operations under several page limits. Depends on prc_pkg and the RTL.
module page_reference_count_table_top_tb;
  import prc_pkg::*;

  localparam int unsigned NUM_PAGES  = NUM_PAGES_DEF;
  localparam int unsigned GROUP_SIZE = GROUP_SIZE_DEF;
  localparam int unsigned PAGE_BITS  = PAGE_BITS_DEF;
  localparam int unsigned COUNT_BITS = COUNT_BITS_DEF;
  localparam int unsigned NUM_GROUPS = (NUM_PAGES + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [OP_W-1:0]       OP_SPARE  = 2'd3;  // unused code, decoded as a query
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Settle time before a limit write, trailing wait at the end, and the
  // quiet-cycle limit (covers the clearing sweep after reset several times)
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned TAIL_CYCLES    = 12;
  localparam int unsigned WATCHDOG_LIMIT = 4 * NUM_PAGES + 1000;

  typedef enum logic [1:0] {RX_FREE, RX_TOGGLE, RX_RANDOM, RX_BLOCKY} rx_mode_e;

  logic               clk_i     = 1'b0;
  logic               rst_ni    = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_t                in_beat   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_t               out_data;
  logic               cfg_we    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;

  page_reference_count_table_top #(
    .NUM_PAGES  (NUM_PAGES),
    .GROUP_SIZE (GROUP_SIZE),
    .PAGE_BITS  (PAGE_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_beat),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial forever #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow of the table: page counts, per-group used counts and present flags,
  // and the number of present groups. All start at zero, as after the sweep.
  // ---------------------------------------------------------------------------
  bit [COUNT_BITS-1:0]        page_cnt    [NUM_PAGES];
  bit [$clog2(GROUP_SIZE):0]  grp_used    [NUM_GROUPS];
  bit                         grp_present [NUM_GROUPS];
  bit [GROUPS_W-1:0]          groups_total;
  logic [LIMIT_W-1:0]         page_limit_shadow = LIMIT_RESET;

  in_t  ops_to_send [$];   // beats waiting for the driver
  out_t replies_due [$];   // predicted results, oldest first

  bit          no_idle = 1'b0;  // set for the back-to-back run
  int unsigned error_count, ops_accepted, results_seen, limit_writes, peak_groups;
  int unsigned status_tally [5];

  // Apply one operation to the shadow table and return the result it should give
  function automatic out_t apply_page_op(in_t beat);
    logic [ADDR_W-PAGE_BITS-1:0] idx;
    int unsigned                 page;
    int unsigned                 grp;
    out_t                        res;
    idx = beat.phys_address[ADDR_W-1:PAGE_BITS];
    res = '0;
    if (idx >= page_limit_shadow || idx >= NUM_PAGES) begin
      // Out of range: nothing changes
      res.status = STAT_RANGE;
    end else begin
      page = idx[31:0];
      grp  = page / GROUP_SIZE;
      case (beat.operation)
        OP_ADD: begin
          // First add into a group brings the group in
          if (!grp_present[grp]) begin
            grp_present[grp] = 1'b1;
            grp_used[grp]    = '0;
            groups_total++;
          end
          if (page_cnt[page] == COUNT_MAX) begin
            res.status    = STAT_SATURATED;
            res.ref_count = page_cnt[page];
          end else begin
            if (page_cnt[page] == '0) grp_used[grp]++;
            page_cnt[page]++;
            res.status    = STAT_OK;
            res.ref_count = page_cnt[page];
          end
        end
        OP_REMOVE: begin
          if (!grp_present[grp]) begin
            res.status = STAT_ABSENT;
          end else if (page_cnt[page] == '0) begin
            res.status = STAT_UNDERFLOW;
          end else begin
            page_cnt[page]--;
            if (page_cnt[page] == '0 && grp_used[grp] != '0) grp_used[grp]--;
            // Last live page gone: free the group
            if (grp_used[grp] == '0) begin
              grp_present[grp] = 1'b0;
              if (groups_total != '0) groups_total--;
            end
            res.status    = STAT_OK;
            res.ref_count = page_cnt[page];
          end
        end
        default: begin
          // Query, and the spare code which behaves the same
          res.status    = STAT_OK;
          res.ref_count = grp_present[grp] ? page_cnt[page] : '0;
        end
      endcase
    end
    res.groups_in_use = groups_total;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: take beats from ops_to_send in bursts with random gaps. Valid is
  // held with its payload until the block takes the beat; the prediction is
  // made at the edge of acceptance.
  // ---------------------------------------------------------------------------
  int unsigned burst_left, gap_left;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        replies_due.push_back(apply_page_op(in_beat));
        ops_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0 && !no_idle) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (ops_to_send.size() != 0) begin
          in_beat  <= ops_to_send.pop_front();
          in_valid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // End of burst: draw the next burst length and the gap before it
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result beat against the oldest prediction, and drive
  // ready high in the back-to-back run, else from a randomly changing mode.
  // ---------------------------------------------------------------------------
  rx_mode_e    rx_mode = RX_FREE;
  int unsigned rx_mode_left, rx_stall_left;
  out_t        want;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.status <= STAT_SATURATED) status_tally[out_data.status]++;
        if (out_data.groups_in_use > peak_groups) peak_groups = 32'(out_data.groups_in_use);
        if (replies_due.size() == 0) begin
          $error("result beat with nothing expected: status %0d ref_count %0d groups %0d",
                 out_data.status, out_data.ref_count, out_data.groups_in_use);
          error_count++;
        end else begin
          want = replies_due.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.ref_count !== want.ref_count) begin
            $error("ref_count: expected %0d, got %0d", want.ref_count, out_data.ref_count);
            error_count++;
          end
          if (out_data.groups_in_use !== want.groups_in_use) begin
            $error("groups_in_use: expected %0d, got %0d",
                   want.groups_in_use, out_data.groups_in_use);
            error_count++;
          end
        end
      end

      if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_e'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(16, 96);
        end else begin
          rx_mode_left--;
        end
        case (rx_mode)
          RX_FREE:   out_ready <= 1'b1;
          RX_TOGGLE: out_ready <= ~out_ready;
          RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
          default: begin
            // Mostly ready, with the odd long stall
            if (rx_stall_left == 0 && $urandom_range(0, 7) == 0)
              rx_stall_left = $urandom_range(4, 12);
            out_ready <= (rx_stall_left == 0);
            if (rx_stall_left != 0) rx_stall_left--;
          end
        endcase
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either side
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
               quiet_cycles, replies_due.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Byte address inside a page, with a random offset
  function automatic logic [ADDR_W-1:0] page_addr(longint unsigned page);
    logic [ADDR_W-1:0] offset;
    offset = ADDR_W'($urandom_range(0, (1 << PAGE_BITS) - 1));
    return (ADDR_W'(page) << PAGE_BITS) | offset;
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_ADD;
    if (r < 80) return OP_REMOVE;
    if (r < 95) return OP_QUERY;
    return OP_SPARE;
  endfunction

  task automatic queue_op(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr);
    in_t b;
    b.operation    = op;
    b.phys_address = addr;
    ops_to_send.push_back(b);
  endtask

  // Random operations, mostly on a handful of pages spread over three groups
  // so that groups come and go; the rest hit random pages, the pages around
  // the limit, and wild addresses.
  task automatic queue_random_ops(int unsigned n);
    longint unsigned   span;
    longint unsigned   hot [8];
    longint unsigned   grp [3];
    int unsigned       pick;
    logic [ADDR_W-1:0] addr;
    span = (page_limit_shadow < NUM_PAGES) ? page_limit_shadow : NUM_PAGES;
    foreach (grp[k]) grp[k] = (span == 0) ? 0 : $urandom_range(0, (span - 1) / GROUP_SIZE);
    foreach (hot[k]) begin
      hot[k] = grp[k % 3] * GROUP_SIZE + $urandom_range(0, GROUP_SIZE - 1);
      if (span != 0 && hot[k] >= span) hot[k] = span - 1;
    end
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (span == 0 || pick >= 92)
        addr = ADDR_W'({$urandom, $urandom});
      else if (pick < 70)
        addr = page_addr(hot[$urandom_range(0, 7)]);
      else if (pick < 82)
        addr = page_addr($urandom_range(0, span - 1));
      else
        addr = page_addr(span - 1 + $urandom_range(0, 2));
      queue_op(pick_op(), addr);
    end
  endtask

  // Wait until the block is idle with nothing owed, then write the limit
  task automatic drain_and_set_limit(logic [LIMIT_W-1:0] value);
    do @(negedge clk_i);
    while (ops_to_send.size() != 0 || in_valid || replies_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    @(posedge clk_i);
    cfg_we            <= 1'b1;
    cfg_wdata         <= value;
    page_limit_shadow  = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    limit_writes++;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part at the reset limit; the write lands during the clearing sweep
    drain_and_set_limit(LIMIT_RESET);
    queue_op(OP_QUERY,  48'h0000_0000_0000);  // query in an absent group
    queue_op(OP_REMOVE, page_addr(0));        // remove from an absent group
    queue_op(OP_ADD,    48'h0000_0000_0000);  // first add creates group 0
    queue_op(OP_ADD,    page_addr(0));
    queue_op(OP_SPARE,  page_addr(0));        // spare code reads as a query
    queue_op(OP_ADD,    page_addr(5));
    queue_op(OP_REMOVE, page_addr(7));        // zero count in a present group
    queue_op(OP_REMOVE, page_addr(0));
    queue_op(OP_REMOVE, page_addr(0));
    queue_op(OP_REMOVE, page_addr(0));        // underflow, group still held by page 5
    queue_op(OP_REMOVE, page_addr(5));        // last live page: group freed
    queue_op(OP_QUERY,  page_addr(5));
    queue_op(OP_ADD,    48'h0000_0FFF_FFFF);  // top page, top byte
    queue_op(OP_ADD,    48'h0000_1000_0000);  // first index past the limit
    queue_op(OP_ADD,    48'hFFFF_FFFF_FFFF);
    queue_op(OP_REMOVE, 48'hFFFF_FFFF_FFFF);
    queue_op(OP_QUERY,  48'hFFFF_FFFF_FFFF);
    queue_op(OP_SPARE,  48'h8000_0000_0000);
    queue_op(OP_ADD,    page_addr(GROUP_SIZE - 1));
    queue_op(OP_ADD,    page_addr(GROUP_SIZE));   // neighbouring group across the boundary
    queue_op(OP_REMOVE, page_addr(GROUP_SIZE));
    queue_op(OP_REMOVE, 48'h0000_0FFF_F000);
    queue_op(OP_QUERY,  page_addr(GROUP_SIZE - 1));

    // Largest limit: a run of adds on one page, back to back
    drain_and_set_limit('1);
    no_idle = 1'b1;
    repeat (20) queue_op(OP_ADD, page_addr(40000));
    queue_op(OP_QUERY,  page_addr(40000));
    queue_op(OP_REMOVE, page_addr(40000));
    queue_op(OP_ADD,    page_addr(40000));
    drain_and_set_limit('1);
    no_idle = 1'b0;
    queue_random_ops(70);

    // Random parts across a spread of limits, the extremes among them
    drain_and_set_limit('0);
    queue_random_ops(15);
    drain_and_set_limit(LIMIT_W'(1));
    queue_random_ops(35);
    drain_and_set_limit(LIMIT_W'(2 * GROUP_SIZE + 5));
    queue_random_ops(90);
    drain_and_set_limit(LIMIT_W'($urandom_range(2, NUM_PAGES - 1)));
    queue_random_ops(90);
    drain_and_set_limit(LIMIT_RESET);
    queue_random_ops(110);
    drain_and_set_limit(LIMIT_W'(GROUP_SIZE));
    queue_random_ops(70);

    // Let everything drain, then wait TAIL_CYCLES for stray beats
    do @(negedge clk_i);
    while (ops_to_send.size() != 0 || in_valid || replies_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run: %0d operations in, %0d results checked, %0d limit writes, peak groups %0d",
             ops_accepted, results_seen, limit_writes, peak_groups);
    $display("Statuses seen: ok %0d, range %0d, absent %0d, underflow %0d, saturated %0d",
             status_tally[STAT_OK], status_tally[STAT_RANGE], status_tally[STAT_ABSENT],
             status_tally[STAT_UNDERFLOW], status_tally[STAT_SATURATED]);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
